/* src/tdgw_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdgw_pkg
// Shared types, widths, register indexes and the 2^-fraction table of the
// truncated distance Gaussian weight block.
// ----------------------------------------------------------------------------
package tdgw_pkg;

  // Field and register widths
  localparam int FEAT_W     = 16;
  localparam int WEIGHT_W   = 16;
  localparam int CLIP_W     = 15;
  localparam int DECAY_W    = 16;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;

  // Accumulator and term widths (sum Q25.16, term Q14.16)
  localparam int DIFF_W = FEAT_W + 1;
  localparam int TERM_W = 2 * CLIP_W;
  localparam int SUM_W  = 41;

  // Shared multiplier: a 25 x 16 unit, operands above 25 bits go in two halves
  localparam int MUL_A_W = 25;
  localparam int MUL_B_W = 16;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;
  localparam int HI_W    = SUM_W - MUL_A_W;
  localparam int WIDE_W  = SUM_W + MUL_B_W;

  // Exponential constants
  localparam logic [MUL_B_W-1:0] LOG2E_Q15 = 16'd47274;
  localparam logic [63:0]        LN2_Q32   = 64'd2977044472;
  localparam int FRAC_W    = 16;
  localparam int Y_W       = WIDE_W - 15;
  localparam int SHIFT_W   = 5;
  localparam int SHIFT_MAX = 20;

  // 2^-fraction table
  localparam int EXP_TABLE_DEPTH = 256;
  localparam int ROM_IDX_W       = $clog2(EXP_TABLE_DEPTH);
  localparam int DEPTH_W         = ROM_IDX_W + 1;
  localparam int FPROD_W         = FRAC_W + DEPTH_W;
  localparam int ROM_W           = 17;
  localparam int SCALE_W         = ROM_W + SHIFT_W;

  // Register reset values
  localparam logic [CLIP_W-1:0]  CLIP_RESET  = 15'd3840;
  localparam logic [DECAY_W-1:0] DECAY_RESET = 16'd6554;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CLIP_DISTANCE = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY_RATE    = 4'd1;

  typedef struct packed {
    logic signed [FEAT_W-1:0] first_value;
    logic signed [FEAT_W-1:0] second_value;
    logic                     last_feature;
  } tdgw_in_t;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic                sum_saturated;
  } tdgw_out_t;

  typedef enum logic [3:0] {
    ST_RUN,
    ST_FOLD,
    ST_MUL_SL,
    ST_MUL_SH,
    ST_SUM_T,
    ST_MUL_TL,
    ST_MUL_TH,
    ST_SUM_Y,
    ST_LOOKUP,
    ST_SCALE
  } tdgw_state_e;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_MUL_SL,
    OP_MUL_SH,
    OP_SUM_T,
    OP_MUL_TL,
    OP_MUL_TH,
    OP_SUM_Y,
    OP_LOOKUP,
    OP_SCALE
  } tdgw_op_e;

  typedef struct packed {
    logic     accept;
    tdgw_op_e op;
  } tdgw_cmd_t;

  typedef struct packed {
    logic out_free;
  } tdgw_stat_t;

  typedef logic [EXP_TABLE_DEPTH-1:0][ROM_W-1:0] tdgw_rom_t;

  // Series term divided by its index
  function automatic logic [63:0] div_small(logic [63:0] v, int unsigned n);
    logic [63:0] r;
    case (n)
      1:       r = v;
      2:       r = v / 2;
      3:       r = v / 3;
      4:       r = v / 4;
      5:       r = v / 5;
      6:       r = v / 6;
      7:       r = v / 7;
      8:       r = v / 8;
      9:       r = v / 9;
      10:      r = v / 10;
      11:      r = v / 11;
      12:      r = v / 12;
      13:      r = v / 13;
      14:      r = v / 14;
      15:      r = v / 15;
      16:      r = v / 16;
      17:      r = v / 17;
      18:      r = v / 18;
      19:      r = v / 19;
      20:      r = v / 20;
      21:      r = v / 21;
      22:      r = v / 22;
      23:      r = v / 23;
      default: r = v;
    endcase
    return r;
  endfunction

  // 2^(-k/EXP_TABLE_DEPTH) in Q1.16 from a 32-bit series for exp(-z)
  function automatic logic [ROM_W-1:0] pow2_neg_frac(int unsigned k);
    logic [63:0] f;
    logic [63:0] z;
    logic [63:0] term;
    logic [63:0] pos;
    logic [63:0] neg;
    logic [63:0] v;
    f    = (64'(k) << 32) / EXP_TABLE_DEPTH;
    z    = (f * LN2_Q32) >> 32;
    term = 64'd1 << 32;
    pos  = term;
    neg  = 64'd0;
    for (int unsigned n = 1; n < 24; n++) begin
      term = div_small((term * z) >> 32, n);
      if (n[0]) begin
        neg = neg + term;
      end else begin
        pos = pos + term;
      end
    end
    v = (pos > neg) ? pos - neg : 64'd0;
    return ROM_W'((v + 64'd32768) >> 16);
  endfunction

  function automatic tdgw_rom_t build_rom();
    tdgw_rom_t r;
    for (int unsigned k = 0; k < EXP_TABLE_DEPTH; k++) begin
      r[k] = pow2_neg_frac(k);
    end
    return r;
  endfunction

  localparam tdgw_rom_t POW2_ROM = build_rom();

endpackage
`default_nettype wire

/* src/tdgw_ctrl.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdgw_ctrl
// Sequencer: streams feature pairs, then walks the exponential tail.
// ----------------------------------------------------------------------------
module tdgw_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  wire                 in_last_i,
  output logic                in_stall_o,
  output logic                cfg_ready_o,
  input  tdgw_pkg::tdgw_stat_t stat_i,
  output tdgw_pkg::tdgw_cmd_t  cmd_o
);
  import tdgw_pkg::*;

  tdgw_state_e state_q, state_d;
  logic        live_q;
  logic        stall;
  logic        accept;

  assign stall       = !live_q || (state_q != ST_RUN);
  assign accept      = in_valid_i && !stall;
  assign in_stall_o  = stall;
  assign cfg_ready_o = live_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      live_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      live_q  <= 1'b1;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN:    if (accept && in_last_i) state_d = ST_FOLD;
      ST_FOLD:   state_d = ST_MUL_SL;
      ST_MUL_SL: state_d = ST_MUL_SH;
      ST_MUL_SH: state_d = ST_SUM_T;
      ST_SUM_T:  state_d = ST_MUL_TL;
      ST_MUL_TL: state_d = ST_MUL_TH;
      ST_MUL_TH: state_d = ST_SUM_Y;
      ST_SUM_Y:  state_d = ST_LOOKUP;
      ST_LOOKUP: state_d = ST_SCALE;
      ST_SCALE:  if (stat_i.out_free) state_d = ST_RUN;
      default:   state_d = ST_RUN;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o.accept = accept;
    case (state_q)
      ST_MUL_SL: cmd_o.op = OP_MUL_SL;
      ST_MUL_SH: cmd_o.op = OP_MUL_SH;
      ST_SUM_T:  cmd_o.op = OP_SUM_T;
      ST_MUL_TL: cmd_o.op = OP_MUL_TL;
      ST_MUL_TH: cmd_o.op = OP_MUL_TH;
      ST_SUM_Y:  cmd_o.op = OP_SUM_Y;
      ST_LOOKUP: cmd_o.op = OP_LOOKUP;
      ST_SCALE:  cmd_o.op = OP_SCALE;
      default:   cmd_o.op = OP_NONE;
    endcase
  end

endmodule
`default_nettype wire

/* src/tdgw_datapath.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tdgw_datapath
// Clipped squared-distance accumulator, shared multiplier for the exponent,
// 2^-fraction lookup, rounding shift and the result register.
// ----------------------------------------------------------------------------
module tdgw_datapath (
  input  wire                                   clk_i,
  input  wire                                   rst_ni,
  input  tdgw_pkg::tdgw_cmd_t                   cmd_i,
  output tdgw_pkg::tdgw_stat_t                  stat_o,
  input  tdgw_pkg::tdgw_in_t                    in_data_i,
  input  wire                                   cfg_we_i,
  input  wire [tdgw_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  wire [tdgw_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  output logic                                  out_valid_o,
  input  wire                                   out_stall_i,
  output tdgw_pkg::tdgw_out_t                   out_data_o
);
  import tdgw_pkg::*;

  // Configuration registers
  logic [CLIP_W-1:0]  clip_q;
  logic [DECAY_W-1:0] decay_q;

  // Accumulator
  logic [TERM_W-1:0]  term_q;
  logic               pend_q;
  logic [SUM_W-1:0]   sum_q, sum_d;
  logic               ovf_q, ovf_d;

  // Exponent tail
  logic [PROD_W-1:0]      prod_q;
  logic [PROD_W-1:0]      lo_q;
  logic [SUM_W-1:0]       t_q;
  logic [FRAC_W-1:0]      frac_q;
  logic [SHIFT_W-1:0]     shift_q;
  logic                   zero_q;
  logic [ROM_W-1:0]       e_q;

  logic                   out_valid_q;
  tdgw_out_t              out_q;

  // Per-feature term
  logic signed [DIFF_W-1:0] diff;
  logic [DIFF_W-1:0]        abs_diff;
  logic [CLIP_W-1:0]        clipped;
  logic [SUM_W:0]           total;

  // Tail logic
  logic [MUL_A_W-1:0]   mul_a;
  logic [MUL_B_W-1:0]   mul_b;
  logic [PROD_W-1:0]    prod;
  logic [WIDE_W-1:0]    wide;
  logic [Y_W-1:0]       y;
  logic                 shift_big;
  logic [FPROD_W-1:0]   fprod;
  logic [ROM_IDX_W-1:0] rom_idx;
  logic [SCALE_W-1:0]   rnd;
  logic [SCALE_W-1:0]   scaled;
  logic [WEIGHT_W-1:0]  weight;
  logic                 out_free;
  logic                 out_write;

  assign diff     = DIFF_W'(in_data_i.first_value) - DIFF_W'(in_data_i.second_value);
  assign abs_diff = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
  assign clipped  = (abs_diff < DIFF_W'(clip_q)) ? abs_diff[CLIP_W-1:0] : clip_q;

  assign total = {1'b0, sum_q} + (SUM_W + 1)'(term_q);

  always_comb begin
    sum_d = sum_q;
    ovf_d = ovf_q;
    if (pend_q) begin
      sum_d = total[SUM_W] ? {SUM_W{1'b1}} : total[SUM_W-1:0];
      ovf_d = ovf_q | total[SUM_W];
    end
    if (out_write) begin
      sum_d = '0;
      ovf_d = 1'b0;
    end
  end

  // Shared multiplier operands
  always_comb begin
    case (cmd_i.op)
      OP_MUL_SL: begin
        mul_a = sum_q[MUL_A_W-1:0];
        mul_b = decay_q;
      end
      OP_MUL_SH: begin
        mul_a = MUL_A_W'(sum_q[SUM_W-1:MUL_A_W]);
        mul_b = decay_q;
      end
      OP_MUL_TL: begin
        mul_a = t_q[MUL_A_W-1:0];
        mul_b = LOG2E_Q15;
      end
      OP_MUL_TH: begin
        mul_a = MUL_A_W'(t_q[SUM_W-1:MUL_A_W]);
        mul_b = LOG2E_Q15;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);

  // Recombine the two partial products
  assign wide = WIDE_W'(lo_q) + {prod_q[WIDE_W-MUL_A_W-1:0], {MUL_A_W{1'b0}}};
  assign y    = wide[WIDE_W-1:15];

  assign shift_big = (|y[Y_W-1:FRAC_W+SHIFT_W])
                  || (y[FRAC_W +: SHIFT_W] > SHIFT_W'(SHIFT_MAX));

  assign fprod   = FPROD_W'(frac_q) * FPROD_W'(EXP_TABLE_DEPTH);
  assign rom_idx = fprod[FRAC_W +: ROM_IDX_W];

  // Round-to-nearest right shift by the integer part
  assign rnd = SCALE_W'(1) << (shift_q - SHIFT_W'(1));

  always_comb begin
    if (zero_q) begin
      scaled = '0;
    end else if (shift_q == '0) begin
      scaled = SCALE_W'(e_q);
    end else begin
      scaled = (SCALE_W'(e_q) + rnd) >> shift_q;
    end
  end

  assign weight = (|scaled[SCALE_W-1:WEIGHT_W]) ? {WEIGHT_W{1'b1}} : scaled[WEIGHT_W-1:0];

  assign out_free  = !out_valid_q || !out_stall_i;
  assign out_write = (cmd_i.op == OP_SCALE) && out_free;

  assign stat_o.out_free = out_free;
  assign out_valid_o     = out_valid_q;
  assign out_data_o      = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clip_q      <= CLIP_RESET;
      decay_q     <= DECAY_RESET;
      pend_q      <= 1'b0;
      sum_q       <= '0;
      ovf_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_CLIP_DISTANCE: clip_q  <= cfg_data_i[CLIP_W-1:0];
          REG_DECAY_RATE:    decay_q <= cfg_data_i[DECAY_W-1:0];
          default: ;
        endcase
      end
      pend_q <= cmd_i.accept;
      sum_q  <= sum_d;
      ovf_q  <= ovf_d;
      if (out_write) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      term_q <= TERM_W'(clipped) * TERM_W'(clipped);
    end
    case (cmd_i.op)
      OP_MUL_SL, OP_MUL_TL: prod_q <= prod;
      OP_MUL_SH, OP_MUL_TH: begin
        lo_q   <= prod_q;
        prod_q <= prod;
      end
      OP_SUM_T: t_q <= wide[WIDE_W-1:16];
      OP_SUM_Y: begin
        frac_q  <= y[FRAC_W-1:0];
        shift_q <= y[FRAC_W +: SHIFT_W];
        zero_q  <= shift_big;
      end
      OP_LOOKUP: e_q <= POW2_ROM[rom_idx];
      default: ;
    endcase
    if (out_write) begin
      out_q.weight        <= weight;
      out_q.sum_saturated <= ovf_q;
    end
  end

endmodule
`default_nettype wire

/* src/truncated_distance_gaussian_weight_core.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// truncated_distance_gaussian_weight_core
// Truncated Gaussian kernel weight between two streamed feature vectors.
// ----------------------------------------------------------------------------
// Stream one feature pair per transaction, both signed Q8.8. Each pair adds
// min(|first - second|, clip_distance)^2 to a 41-bit Q25.16 sum that sticks
// at its maximum and flags the overflow. The transaction marked last_feature
// closes the row pair: its result is exp(-decay_rate * sum) in unsigned
// Q0.16, with 1.0 reading as 65535, together with the overflow flag; the sum
// and flag then clear for the next pair. Pairs that are not last may arrive
// back to back. After a last pair is taken, the input stalls while a fold
// step adds its term into the sum, then the exponent runs through a single
// shared 25x16 multiplier in four passes (sum times decay, then times
// log2(e), each in two halves), a 2^-fraction table lookup and a rounding
// shift. The result is written to the output register as the sequencer
// goes back to taking feature pairs, so the input restarts while the
// result waits; if an older result is still stalled there, the tail holds
// until it drains. Write configuration only between row pairs, with no
// result pending; the port is ready from the first cycle after reset.
// ----------------------------------------------------------------------------
module truncated_distance_gaussian_weight_core (
  input  wire                               clk_i,
  input  wire                               rst_ni,
  // feature pair input
  input  wire                               in_valid_i,
  output logic                              in_stall_o,
  input  tdgw_pkg::tdgw_in_t                in_data_i,
  // weight output
  output logic                              out_valid_o,
  input  wire                               out_stall_i,
  output tdgw_pkg::tdgw_out_t               out_data_o,
  // register writes
  input  wire                               cfg_valid_i,
  output logic                              cfg_ready_o,
  input  wire [tdgw_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire [tdgw_pkg::CFG_DATA_W-1:0]    cfg_data_i
);
  import tdgw_pkg::*;

  tdgw_cmd_t  cmd;
  tdgw_stat_t stat;
  logic       cfg_we;

  // A register write completes when both sides agree
  assign cfg_we = cfg_valid_i && cfg_ready_o;

  // Sequencer: owns the input handshake and the tail order
  tdgw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_last_i   (in_data_i.last_feature),
    .in_stall_o  (in_stall_o),
    .cfg_ready_o (cfg_ready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  // Arithmetic, configuration registers and the output register
  tdgw_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  // A last pair always starts the tail, which blocks the input
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_feature |=> in_stall_o)
    else $error("input not held after last feature pair");

  // A new result only appears at the end of a tail
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result produced outside the exponent tail");

  // The input is only blocked after a last pair was taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i && in_data_i.last_feature))
    else $error("input blocked without a closing feature pair");

endmodule
`default_nettype wire
